/* rtl/ppu_pkg.sv */
// shared types, constants and helper functions of the particle pool
package ppu_pkg;

  localparam int POOL_SIZE_DEF = 64;
  localparam int SLOT_W        = 6;
  localparam int CNT_W         = 7;
  localparam int Q_W           = 16;
  localparam int DT_W          = 16;
  localparam int CMD_W         = 2;
  localparam int BURST_W       = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int COLOR_W       = 32;
  localparam int RATE_W        = 24;
  localparam int FRAC_W        = 17;
  localparam int DRAW_N        = 8;
  localparam int MIX_N         = 5;

  localparam logic [CNT_W-1:0]  BURST_DEFAULT = CNT_W'(10);
  localparam logic [FRAC_W-1:0] FRAC_ONE      = FRAC_W'(65536);
  localparam logic [Q_W-1:0]    GRAVITY_RESET = 16'hF633;
  localparam logic [31:0]       SEED_RESET    = 32'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_BURST = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMISSION_RATE  = 3'd0,
    REG_GRAVITY_Y      = 3'd1,
    REG_SPAWN_POSITION = 3'd2,
    REG_SPAWN_VELOCITY = 3'd3,
    REG_SPREAD         = 3'd4,
    REG_COLOR_RANGE    = 3'd5,
    REG_SIZE_AND_LIFE  = 3'd6,
    REG_RNG_SEED       = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT_MUL,
    ST_EMIT_ACC,
    ST_SPAWN_DRAW,
    ST_SPAWN_WRITE,
    ST_UPD_READ,
    ST_UPD_LOAD,
    ST_UPD_MUL,
    ST_UPD_ADD,
    ST_UPD_WRITE,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_DIV,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic [Q_W-1:0] pos_x;
    logic [Q_W-1:0] pos_y;
    logic [Q_W-1:0] pos_z;
    logic [Q_W-1:0] vel_x;
    logic [Q_W-1:0] vel_y;
    logic [Q_W-1:0] vel_z;
    logic [Q_W-1:0] life_left;
    logic [Q_W-1:0] life_total;
    logic [Q_W-1:0] start_size;
  } particle_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic logic [Q_W-1:0] sat_s16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'h7FFF;
    if (v < -20'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [Q_W-1:0] sat_u16(input logic signed [19:0] v);
    if (v > 20'sd65535) return 16'hFFFF;
    if (v < 20'sd0) return 16'h0000;
    return v[15:0];
  endfunction

endpackage

/* rtl/ppu_in_if.sv */
// command channel: one item per tick, burst or clear
interface ppu_in_if import ppu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [DT_W-1:0]    delta_time;
  logic [BURST_W-1:0] burst_count;

  modport source (output valid, command, delta_time, burst_count, input ready);
  modport sink (input valid, command, delta_time, burst_count, output ready);
endinterface

/* rtl/ppu_out_if.sv */
// result channel: one item per pool slot after a tick
interface ppu_out_if import ppu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SLOT_W-1:0]       slot;
  logic                    alive;
  logic signed [Q_W-1:0]   pos_x;
  logic signed [Q_W-1:0]   pos_y;
  logic signed [Q_W-1:0]   pos_z;
  logic [Q_W-1:0]          size_now;
  logic [COLOR_W-1:0]      color_now;
  logic [CNT_W-1:0]        live_total;
  logic                    last;

  modport source (output valid, slot, alive, pos_x, pos_y, pos_z, size_now, color_now,
                  live_total, last, input ready);
  modport sink (input valid, slot, alive, pos_x, pos_y, pos_z, size_now, color_now,
                live_total, last, output ready);
endinterface

/* rtl/ppu_cfg_if.sv */
// register write channel
interface ppu_cfg_if import ppu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ppu_ram.sv */
// generic single-write, single-read ram with registered read data
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppu_div.sv */
// restoring divider for the life fraction, one quotient bit per cycle
module ppu_div import ppu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [Q_W-1:0]    num,
  input  logic [Q_W-1:0]    den,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [Q_W:0]      rem;
  logic [Q_W-1:0]    den_r;
  logic [FRAC_W-1:0] quo_r;
  logic              ge;
  logic [Q_W:0]      rem_sub;

  assign ge      = rem >= {1'b0, den_r};
  assign rem_sub = ge ? rem - {1'b0, den_r} : rem;
  assign quo     = quo_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(FRAC_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // first compare gives the integer bit, then the fraction bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy) begin
      rem   <= {rem_sub[Q_W-1:0], 1'b0};
      quo_r <= {quo_r[FRAC_W-2:0], ge};
    end
  end

endmodule

/* rtl/particle_pool_update.sv */
// Particle pool engine. Particle state sits in one ram of POOL_SIZE entries with live bits in
// flops. A clear drops all live bits. A burst builds each particle from eight xorshift draws and
// one ram write. A tick runs the emission math, spawns the emitted particles the same way, then an
// update walk that skips dead slots, retires slots that expire and moves every surviving slot (one
// shared multiplier does gravity and the three position axes), then a result walk that sends each
// dead slot as zeros and runs, for a live slot, the 17-step life fraction divider (skipped when the
// life total is zero) and five interpolations on the same multiplier. No new command is taken until
// the last slot result is taken. Configuration writes are taken in every cycle out of reset.
module particle_pool_update import ppu_pkg::*; #(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input logic       clk,
  input logic       rst,
  ppu_in_if.sink    cmd,
  ppu_out_if.source res,
  ppu_cfg_if.sink   cfg
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam logic [IW-1:0] SLOT_LAST = IW'(POOL_SIZE - 1);

  state_t state, state_next;

  // configuration
  logic [RATE_W-1:0] emission_rate;
  logic [Q_W-1:0]    gravity_y;
  logic [47:0]       spawn_position;
  logic [47:0]       spawn_velocity;
  logic [63:0]       spread;
  logic [63:0]       color_range;
  logic [47:0]       size_and_life;

  // engine state
  logic [31:0]         rng_state;
  logic [31:0]         acc;
  logic [IW-1:0]       cursor;
  logic [POOL_SIZE-1:0] live_flag;

  // working registers
  logic [DT_W-1:0]     dt;
  logic [39:0]         emit_prod;
  logic [Q_W-1:0]      gdt;
  logic [CNT_W-1:0]    spawn_cnt;
  logic                is_tick;
  logic [2:0]          draw_idx;
  logic [Q_W-1:0]      draw_val [DRAW_N];
  logic [IW-1:0]       slot_idx;
  logic [CNT_W-1:0]    live_cnt;
  particle_t           part;
  particle_t           part_upd;
  logic [1:0]          axis;
  logic [2:0]          mix_ch;
  logic [FRAC_W-1:0]   frac;
  logic signed [34:0]  mul_prod;

  // result register
  logic [SLOT_W-1:0]   out_slot;
  logic                out_alive;
  logic [Q_W-1:0]      out_pos_x, out_pos_y, out_pos_z, out_size;
  logic [COLOR_W-1:0]  out_color;
  logic [CNT_W-1:0]    out_live;
  logic                out_last;

  // ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  particle_t     ram_wdata, ram_rdata, spawn_part;

  // divider
  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quo;

  // combinational datapath
  logic [32:0]         acc_sum;
  logic [31:0]         acc_sat;
  logic [CNT_W-1:0]    spawn_n;
  logic [8:0]          step;
  logic                slot_last;
  logic [IW-1:0]       slot_inc;
  logic                retire;
  logic [31:0]         rng_next;
  logic signed [9:0]   samp;
  logic [7:0]          var8;
  logic signed [18:0]  off_prod;
  logic signed [18:0]  offset;
  logic signed [17:0]  draw_base;
  logic signed [19:0]  draw_sum;
  logic [Q_W-1:0]      draw_res;
  logic [Q_W-1:0]      vel_sel, pos_sel;
  logic signed [19:0]  pos_sum;
  logic signed [19:0]  vy_sum;
  logic [Q_W-1:0]      mix_begin, mix_end;
  logic signed [16:0]  mix_diff;
  logic signed [35:0]  mix_round;
  logic [Q_W-1:0]      mix_val;
  logic signed [16:0]  mul_a;
  logic signed [17:0]  mul_b;

  ppu_ram #(
    .WIDTH ($bits(particle_t)),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  ppu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ram_rdata.life_left),
    .den   (ram_rdata.life_total),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg.ready = !rst;

  assign res.slot       = out_slot;
  assign res.alive      = out_alive;
  assign res.pos_x      = out_pos_x;
  assign res.pos_y      = out_pos_y;
  assign res.pos_z      = out_pos_z;
  assign res.size_now   = out_size;
  assign res.color_now  = out_color;
  assign res.live_total = out_live;
  assign res.last       = out_last;

  // emission and aging step
  assign acc_sum   = {1'b0, acc} + {1'b0, emit_prod[39:8]};
  assign acc_sat   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign spawn_n   = (acc_sat[31:16] > 16'(POOL_SIZE)) ? CNT_W'(POOL_SIZE)
                                                        : CNT_W'(acc_sat[31:16]);
  assign step      = 9'(({1'b0, dt} + 17'd128) >> 8);
  assign slot_last = slot_idx == SLOT_LAST;
  assign slot_inc  = slot_last ? '0 : slot_idx + 1'b1;
  assign retire    = ram_rdata.life_left <= {7'd0, step};

  // spread draw
  assign rng_next = xorshift32(rng_state);
  assign samp     = $signed({1'b0, rng_next[31:23]}) - 10'sd256;
  assign var8     = spread[{~draw_idx, 3'b000} +: 8];
  assign off_prod = samp * $signed({1'b0, var8});
  assign offset   = off_prod >>> 4;
  assign draw_sum = {{2{draw_base[17]}}, draw_base} + {offset[18], offset};
  assign draw_res = (draw_idx < 3'd6) ? sat_s16(draw_sum) : sat_u16(draw_sum);

  always_comb begin
    case (draw_idx)
      3'd0:    draw_base = {{2{spawn_position[47]}}, spawn_position[47:32]};
      3'd1:    draw_base = {{2{spawn_position[31]}}, spawn_position[31:16]};
      3'd2:    draw_base = {{2{spawn_position[15]}}, spawn_position[15:0]};
      3'd3:    draw_base = {{2{spawn_velocity[47]}}, spawn_velocity[47:32]};
      3'd4:    draw_base = {{2{spawn_velocity[31]}}, spawn_velocity[31:16]};
      3'd5:    draw_base = {{2{spawn_velocity[15]}}, spawn_velocity[15:0]};
      3'd6:    draw_base = {2'b00, size_and_life[47:32]};
      default: draw_base = {2'b00, size_and_life[15:0]};
    endcase
  end

  always_comb begin
    spawn_part.pos_x      = draw_val[0];
    spawn_part.pos_y      = draw_val[1];
    spawn_part.pos_z      = draw_val[2];
    spawn_part.vel_x      = draw_val[3];
    spawn_part.vel_y      = draw_val[4];
    spawn_part.vel_z      = draw_val[5];
    spawn_part.start_size = draw_val[6];
    spawn_part.life_total = draw_val[7];
    spawn_part.life_left  = draw_val[7];
  end

  assign ram_waddr = (state == ST_SPAWN_WRITE) ? cursor : slot_idx;
  assign ram_wdata = (state == ST_SPAWN_WRITE) ? spawn_part : part;

  // aged particle with gravity applied
  always_comb begin
    part_upd           = ram_rdata;
    part_upd.life_left = ram_rdata.life_left - {7'd0, step};
    part_upd.vel_y     = sat_s16(vy_sum);
  end

  // position update per axis
  always_comb begin
    case (axis)
      2'd0:    begin vel_sel = part.vel_x; pos_sel = part.pos_x; end
      2'd1:    begin vel_sel = part.vel_y; pos_sel = part.pos_y; end
      default: begin vel_sel = part.vel_z; pos_sel = part.pos_z; end
    endcase
  end

  assign pos_sum = {{4{pos_sel[15]}}, pos_sel} + {mul_prod[34], mul_prod[34:16]};
  assign vy_sum  = {{4{ram_rdata.vel_y[15]}}, ram_rdata.vel_y} + {{4{gdt[15]}}, gdt};

  // interpolation: end + round((begin - end) * f / 65536)
  always_comb begin
    case (mix_ch)
      3'd1:    begin mix_begin = {8'd0, color_range[63:56]}; mix_end = {8'd0, color_range[31:24]}; end
      3'd2:    begin mix_begin = {8'd0, color_range[55:48]}; mix_end = {8'd0, color_range[23:16]}; end
      3'd3:    begin mix_begin = {8'd0, color_range[47:40]}; mix_end = {8'd0, color_range[15:8]};  end
      3'd4:    begin mix_begin = {8'd0, color_range[39:32]}; mix_end = {8'd0, color_range[7:0]};   end
      default: begin mix_begin = part.start_size;            mix_end = size_and_life[31:16];       end
    endcase
  end

  assign mix_diff  = $signed({1'b0, mix_begin}) - $signed({1'b0, mix_end});
  assign mix_round = {mul_prod[34], mul_prod} + 36'sd32768;
  assign mix_val   = mix_end + mix_round[31:16];

  // one shared multiplier: gravity, position axes, interpolation
  always_comb begin
    case (state)
      ST_EMIT_MUL: begin mul_a = {gravity_y[15], gravity_y}; mul_b = {2'b00, dt}; end
      ST_UPD_MUL:  begin mul_a = {vel_sel[15], vel_sel};     mul_b = {2'b00, dt}; end
      default:     begin mul_a = mix_diff;                   mul_b = {1'b0, frac}; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    res.valid  = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = !rst;
        if (cmd.valid) begin
          case (cmd_t'(cmd.command))
            CMD_TICK:  state_next = ST_EMIT_MUL;
            CMD_BURST: state_next = ST_SPAWN_DRAW;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_EMIT_MUL: state_next = ST_EMIT_ACC;
      ST_EMIT_ACC: state_next = (spawn_n == '0) ? ST_UPD_READ : ST_SPAWN_DRAW;
      ST_SPAWN_DRAW: begin
        if (draw_idx == 3'(DRAW_N - 1)) state_next = ST_SPAWN_WRITE;
      end
      ST_SPAWN_WRITE: begin
        ram_we = 1'b1;
        if (spawn_cnt == CNT_W'(1)) begin
          state_next = is_tick ? ST_UPD_READ : ST_IDLE;
        end else begin
          state_next = ST_SPAWN_DRAW;
        end
      end
      ST_UPD_READ: begin
        if (live_flag[slot_idx]) state_next = ST_UPD_LOAD;
        else if (slot_last) state_next = ST_OUT_READ;
      end
      ST_UPD_LOAD: begin
        if (retire) state_next = slot_last ? ST_OUT_READ : ST_UPD_READ;
        else state_next = ST_UPD_MUL;
      end
      ST_UPD_MUL: state_next = ST_UPD_ADD;
      ST_UPD_ADD: state_next = (axis == 2'd2) ? ST_UPD_WRITE : ST_UPD_MUL;
      ST_UPD_WRITE: begin
        ram_we     = 1'b1;
        state_next = slot_last ? ST_OUT_READ : ST_UPD_READ;
      end
      ST_OUT_READ: state_next = live_flag[slot_idx] ? ST_OUT_LOAD : ST_OUT_SEND;
      ST_OUT_LOAD: begin
        if (ram_rdata.life_total == '0) begin
          state_next = ST_MIX_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_OUT_DIV;
        end
      end
      ST_OUT_DIV: begin
        if (div_done) state_next = ST_MIX_MUL;
      end
      ST_MIX_MUL: state_next = ST_MIX_ADD;
      ST_MIX_ADD: state_next = (mix_ch == 3'(MIX_N - 1)) ? ST_OUT_SEND : ST_MIX_MUL;
      ST_OUT_SEND: begin
        res.valid = 1'b1;
        if (res.ready) state_next = out_last ? ST_IDLE : ST_OUT_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration, generator and pool bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      emission_rate  <= '0;
      gravity_y      <= GRAVITY_RESET;
      spawn_position <= '0;
      spawn_velocity <= '0;
      spread         <= '0;
      color_range    <= '0;
      size_and_life  <= '0;
      rng_state      <= SEED_RESET;
      acc            <= '0;
      cursor         <= '0;
      live_flag      <= '0;
    end else begin
      if (state == ST_SPAWN_DRAW) rng_state <= rng_next;
      if (cfg.valid) begin
        case (reg_idx_t'(cfg.index))
          REG_EMISSION_RATE:  emission_rate  <= cfg.data[RATE_W-1:0];
          REG_GRAVITY_Y:      gravity_y      <= cfg.data[Q_W-1:0];
          REG_SPAWN_POSITION: spawn_position <= cfg.data[47:0];
          REG_SPAWN_VELOCITY: spawn_velocity <= cfg.data[47:0];
          REG_SPREAD:         spread         <= cfg.data;
          REG_COLOR_RANGE:    color_range    <= cfg.data;
          REG_SIZE_AND_LIFE:  size_and_life  <= cfg.data[47:0];
          REG_RNG_SEED: begin
            rng_state <= (cfg.data[31:0] == '0) ? SEED_RESET : cfg.data[31:0];
          end
          default: ;
        endcase
      end
      if (state == ST_IDLE && cmd.valid && cmd_t'(cmd.command) == CMD_CLEAR) begin
        live_flag <= '0;
      end
      if (state == ST_EMIT_ACC) begin
        acc <= acc_sat - {9'd0, spawn_n, 16'd0};
      end
      if (state == ST_SPAWN_WRITE) begin
        live_flag[cursor] <= 1'b1;
        cursor            <= (cursor == SLOT_LAST) ? '0 : cursor + 1'b1;
      end
      if (state == ST_UPD_LOAD && retire) begin
        live_flag[slot_idx] <= 1'b0;
      end
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_idx  <= '0;
      spawn_cnt <= '0;
      draw_idx  <= '0;
      live_cnt  <= '0;
      is_tick   <= 1'b0;
      axis      <= '0;
      mix_ch    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          draw_idx <= '0;
          if (cmd.valid) begin
            is_tick   <= cmd_t'(cmd.command) == CMD_TICK;
            spawn_cnt <= (cmd.burst_count == '0) ? BURST_DEFAULT : CNT_W'(cmd.burst_count);
          end
        end
        ST_EMIT_ACC: begin
          spawn_cnt <= spawn_n;
          slot_idx  <= '0;
          live_cnt  <= '0;
        end
        ST_SPAWN_DRAW:  draw_idx <= draw_idx + 1'b1;
        ST_SPAWN_WRITE: begin
          spawn_cnt <= spawn_cnt - 1'b1;
          draw_idx  <= '0;
        end
        ST_UPD_READ: begin
          if (!live_flag[slot_idx]) slot_idx <= slot_inc;
        end
        ST_UPD_LOAD: begin
          axis <= '0;
          if (retire) slot_idx <= slot_inc;
        end
        ST_UPD_ADD: axis <= axis + 1'b1;
        ST_UPD_WRITE: begin
          live_cnt <= live_cnt + 1'b1;
          slot_idx <= slot_inc;
        end
        ST_OUT_LOAD: mix_ch <= '0;
        ST_MIX_ADD:  mix_ch <= mix_ch + 1'b1;
        ST_OUT_SEND: begin
          if (res.ready) slot_idx <= slot_inc;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        dt <= cmd.delta_time;
      end
      ST_EMIT_MUL: begin
        emit_prod <= emission_rate * dt;
      end
      ST_EMIT_ACC: begin
        gdt <= mul_prod[31:16];
      end
      ST_SPAWN_DRAW: begin
        draw_val[draw_idx] <= draw_res;
      end
      ST_UPD_LOAD: begin
        part <= part_upd;
      end
      ST_UPD_ADD: begin
        case (axis)
          2'd0:    part.pos_x <= sat_s16(pos_sum);
          2'd1:    part.pos_y <= sat_s16(pos_sum);
          default: part.pos_z <= sat_s16(pos_sum);
        endcase
      end
      ST_OUT_READ: begin
        out_slot  <= SLOT_W'(slot_idx);
        out_last  <= slot_last;
        out_live  <= live_cnt;
        out_alive <= 1'b0;
        out_pos_x <= '0;
        out_pos_y <= '0;
        out_pos_z <= '0;
        out_size  <= '0;
        out_color <= '0;
      end
      ST_OUT_LOAD: begin
        part      <= ram_rdata;
        frac      <= '0;
        out_alive <= 1'b1;
        out_pos_x <= ram_rdata.pos_x;
        out_pos_y <= ram_rdata.pos_y;
        out_pos_z <= ram_rdata.pos_z;
      end
      ST_OUT_DIV: begin
        if (div_done) frac <= (div_quo > FRAC_ONE) ? FRAC_ONE : div_quo;
      end
      ST_MIX_ADD: begin
        case (mix_ch)
          3'd1:    out_color[31:24] <= mix_val[7:0];
          3'd2:    out_color[23:16] <= mix_val[7:0];
          3'd3:    out_color[15:8]  <= mix_val[7:0];
          3'd4:    out_color[7:0]   <= mix_val[7:0];
          default: out_size         <= mix_val;
        endcase
      end
      default: ;
    endcase
  end

  a_no_cmd_while_result: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !cmd.ready)
    else $error("command taken while a slot result is pending");

  a_dead_slot_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.alive |-> res.pos_x == '0 && res.pos_y == '0 && res.pos_z == '0 &&
                                res.size_now == '0 && res.color_now == '0)
    else $error("dead slot result carries nonzero fields");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.live_total <= CNT_W'(POOL_SIZE))
    else $error("live count exceeds pool size");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_OUT_DIV)
    else $error("divider finished outside the result walk");

  a_slot_gap: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !res.last |=> !res.valid)
    else $error("next slot result shown without a ram read");

endmodule
